>>> hw/rtl/lxm_pkg.sv
// Shared types, constants and tables of the LCG XOR decryptor with MD5 check.
`timescale 1ns / 1ps
`default_nettype none
package lxm_pkg;

  localparam int POS_W = 18;             // byte counter, saturates
  localparam int CNT_W = 61;             // MD5 byte count (bit count / 8)
  localparam int MAX_PLAIN_BYTES = 65536;
  localparam int CAP_W = 17;

  localparam logic [31:0] KEY_MASK = 32'hcb0baf47;
  localparam logic [31:0] KEY_MUL  = 32'h0000b8f7;
  localparam logic [31:0] KEY_ADD  = 32'h00015bb9;
  localparam logic [31:0] SANITY   = 32'h42ffdfa9;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;

  // final status codes
  localparam logic [2:0] STAT_OK     = 3'd0;
  localparam logic [2:0] STAT_SANITY = 3'd1;
  localparam logic [2:0] STAT_DIGEST = 3'd2;
  localparam logic [2:0] STAT_SHORT  = 3'd3;
  localparam logic [2:0] STAT_CAP    = 3'd4;

  // configuration register indexes
  localparam logic CFG_CHECKSUM_SELECT = 1'b0;
  localparam logic CFG_PLAIN_CAPACITY  = 1'b1;

  typedef enum logic [1:0] {S_IDLE, S_COMP, S_FIN, S_OUT} state_t;
  typedef enum logic [1:0] {FP_SALT, FP_PAD, FP_ZERO, FP_LEN} fphase_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // input transaction this cycle
    logic comp_load;   // load working registers from chain
    logic round;       // one MD5 round
    logic fin_byte;    // feed one finalization byte
    logic final_load;  // load final result, clear message state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic acc_fill;    // accepted byte completes a block
    logic fin_fill;    // finalization byte completes a block
    logic fin_end;     // finalization byte is the last length byte
    logic rnd_last;    // round 63
    logic out_free;    // output register can take a transaction
  } sts_t;

  // salt tables, table select in index bit 6
  localparam logic [7:0] SALT_TAB [128] = '{
    8'h41,8'h47,8'hc8,8'h09,8'hba,8'h3c,8'h99,8'h6a,8'hda,8'h09,8'h9a,8'h0f,8'hc0,8'hd3,8'h47,8'hca,
    8'hd1,8'h95,8'h81,8'h19,8'hab,8'h17,8'hc6,8'h5f,8'had,8'hea,8'he5,8'h75,8'h9c,8'h49,8'h18,8'ha5,
    8'hdf,8'h35,8'h46,8'h5b,8'h78,8'h0e,8'hcb,8'hc7,8'h8c,8'h3e,8'hf4,8'h90,8'ha2,8'hb7,8'h8e,8'h00,
    8'h53,8'h8d,8'h4c,8'hab,8'h13,8'ha5,8'h16,8'h00,8'hff,8'hb8,8'h4b,8'h20,8'h29,8'h22,8'h9d,8'hee,
    8'hda,8'h76,8'h5c,8'hd4,8'h34,8'hc3,8'hd7,8'h2c,8'hac,8'h40,8'hb8,8'hd8,8'h59,8'hbc,8'h59,8'h34,
    8'haa,8'hbf,8'h89,8'hbd,8'h85,8'he8,8'h40,8'h27,8'h78,8'h2b,8'h18,8'h6e,8'ha6,8'h6e,8'h5a,8'hc6,
    8'hda,8'he3,8'h86,8'h84,8'h40,8'h14,8'h2a,8'h23,8'h4f,8'h5d,8'h38,8'h5e,8'h7f,8'hd9,8'h73,8'h7d,
    8'he4,8'h80,8'h3d,8'h21,8'h28,8'h41,8'hf1,8'hb2,8'h96,8'h43,8'h2b,8'hcc,8'h0c,8'h9d,8'h26,8'hb9
  };

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,32'hf57c0faf,32'h4787c62a,32'ha8304613,32'hfd469501,
    32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,
    32'hf61e2562,32'hc040b340,32'h265e5a51,32'he9b6c7aa,32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
    32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,32'ha9e3e905,32'hfcefa3f8,32'h676f02d9,32'h8d2a4c8a,
    32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,
    32'h289b7ec6,32'heaa127fa,32'hd4ef3085,32'h04881d05,32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
    32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,32'h655b59c3,32'h8f0ccc92,32'hffeff47d,32'h85845dd1,
    32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391
  };

  localparam logic [4:0] MD5_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

endpackage
`default_nettype wire

>>> hw/rtl/lxm_ctrl.sv
// Controller state machine: byte intake, MD5 compression, finalization, result.
`timescale 1ns / 1ps
`default_nettype none
module lxm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_tlast,
  output logic               in_tready,
  input  wire lxm_pkg::sts_t sts,
  output lxm_pkg::cmd_t      cmd
);

  lxm_pkg::state_t state_r, state_nxt;
  logic last_r, last_nxt;        // message ended, finalization pending
  logic fin_end_r, fin_end_nxt;  // compression in progress is the final one

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lxm_pkg::S_IDLE;
      last_r    <= 1'b0;
      fin_end_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      last_r    <= last_nxt;
      fin_end_r <= fin_end_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    last_nxt    = last_r;
    fin_end_nxt = fin_end_r;
    cmd         = '0;
    in_tready   = 1'b0;
    case (state_r)
      lxm_pkg::S_IDLE: begin
        in_tready  = sts.out_free;
        cmd.accept = in_tvalid && sts.out_free;
        if (cmd.accept) begin
          last_nxt = in_tlast;
          if (sts.acc_fill) begin
            cmd.comp_load = 1'b1;
            state_nxt     = lxm_pkg::S_COMP;
          end else if (in_tlast) begin
            state_nxt = lxm_pkg::S_FIN;
          end
        end
      end
      lxm_pkg::S_COMP: begin
        cmd.round = 1'b1;
        if (sts.rnd_last) begin
          if (fin_end_r) begin
            fin_end_nxt = 1'b0;
            state_nxt   = lxm_pkg::S_OUT;
          end else if (last_r) begin
            state_nxt = lxm_pkg::S_FIN;
          end else begin
            state_nxt = lxm_pkg::S_IDLE;
          end
        end
      end
      lxm_pkg::S_FIN: begin
        cmd.fin_byte = 1'b1;
        if (sts.fin_fill) begin
          cmd.comp_load = 1'b1;
          fin_end_nxt   = sts.fin_end;
          state_nxt     = lxm_pkg::S_COMP;
        end
      end
      lxm_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.final_load = 1'b1;
          last_nxt       = 1'b0;
          state_nxt      = lxm_pkg::S_IDLE;
        end
      end
      default: state_nxt = lxm_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/lxm_dp.sv
// Datapath: key stream, header capture, MD5 round unit, padding sequencer, result register.
`timescale 1ns / 1ps
`default_nettype none
module lxm_dp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_addr,
  input  wire logic [lxm_pkg::CAP_W-1:0] cfg_wdata,
  input  wire logic [7:0]                in_byte,
  input  wire logic                      in_last,
  input  wire lxm_pkg::cmd_t             cmd,
  output lxm_pkg::sts_t                  sts,
  input  wire logic                      out_tready,
  output logic                           out_valid,
  output logic [7:0]                     out_plain,
  output logic                           out_bv,
  output logic                           out_done,
  output logic [2:0]                     out_stat,
  output logic [31:0]                    out_time,
  output logic [lxm_pkg::CAP_W-1:0]      out_len
);

  // configuration
  logic                      sel_r;
  logic [lxm_pkg::CAP_W-1:0] cap_r;

  // message state
  logic [lxm_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]               key_r, key_nxt;
  logic [31:0]               san_r, san_nxt;
  logic [31:0]               time_r, time_nxt;
  logic [127:0]              exp_r, exp_nxt;
  logic [1:0]                flags_r, flags_nxt;
  logic                      hold_emit_r, hold_emit_nxt;
  logic [7:0]                hold_d_r, hold_d_nxt;
  logic [lxm_pkg::CNT_W-1:0] cnt_r;
  logic [31:0]               buf_r [16];
  logic [31:0]               h_r [4];
  logic [31:0]               a_r, b_r, c_r, d_r;
  logic [5:0]                rnd_r;
  lxm_pkg::fphase_t          fph_r;
  logic [5:0]                fcnt_r;
  logic [63:0]               lenb_r;

  // output register
  logic                      ov_r, oplain_bv_r, odone_r;
  logic [7:0]                oplain_r;
  logic [2:0]                ostat_r;
  logic [31:0]               otime_r;
  logic [lxm_pkg::CAP_W-1:0] olen_r;

  logic [31:0]               key_step;
  logic [7:0]                dec;
  logic [31:0]               san_sh;
  logic [lxm_pkg::POS_W-1:0] idx;
  logic                      emit;
  logic [3:0]                eidx;
  logic [5:0]                n;
  logic                      wr_en;
  logic [7:0]                wr_byte, fin_b;
  logic                      match;
  logic [2:0]                st;
  logic [lxm_pkg::POS_W-1:0] len_m32;

  assign n        = cnt_r[5:0];
  assign key_step = 32'(key_r * lxm_pkg::KEY_MUL) + lxm_pkg::KEY_ADD;
  assign dec      = in_byte ^ key_step[7:0];
  assign san_sh   = {san_r[23:0], dec};
  assign idx      = pos_r - lxm_pkg::POS_W'(32);
  assign eidx     = pos_r[3:0] ^ 4'd8;
  assign match    = ({h_r[3], h_r[2], h_r[1], h_r[0]} == exp_r);
  assign len_m32  = pos_r - lxm_pkg::POS_W'(32);

  // status to controller
  assign sts.acc_fill = (pos_r >= lxm_pkg::POS_W'(24)) && (n == 6'd63);
  assign sts.fin_fill = (n == 6'd63);
  assign sts.fin_end  = (fph_r == lxm_pkg::FP_LEN) && (fcnt_r[2:0] == 3'd7);
  assign sts.rnd_last = (rnd_r == 6'd63);
  assign sts.out_free = !ov_r || out_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
      cap_r <= lxm_pkg::CAP_W'(65536);
    end else if (cfg_we) begin
      case (cfg_addr)
        lxm_pkg::CFG_CHECKSUM_SELECT: sel_r <= cfg_wdata[0];
        lxm_pkg::CFG_PLAIN_CAPACITY:  cap_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // per-byte header, key and check logic
  always_comb begin
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    san_nxt       = san_r;
    time_nxt      = time_r;
    exp_nxt       = exp_r;
    flags_nxt     = flags_r;
    hold_emit_nxt = hold_emit_r;
    hold_d_nxt    = hold_d_r;
    emit          = 1'b0;
    if (cmd.accept) begin
      if (pos_r == lxm_pkg::POS_W'(1)) begin
        key_nxt[15:8] = in_byte;
      end else if (pos_r == lxm_pkg::POS_W'(2)) begin
        key_nxt[31:24] = in_byte;
      end else if (pos_r == lxm_pkg::POS_W'(4)) begin
        key_nxt[23:16] = in_byte;
      end else if (pos_r == lxm_pkg::POS_W'(7)) begin
        key_nxt = {key_r[31:8], in_byte} ^ lxm_pkg::KEY_MASK;
      end else if (pos_r >= lxm_pkg::POS_W'(8) && pos_r < lxm_pkg::POS_W'(24)) begin
        exp_nxt[{eidx, 3'b000} +: 8] = in_byte;
      end
      if (pos_r >= lxm_pkg::POS_W'(24)) begin
        key_nxt = key_step;
        if (pos_r < lxm_pkg::POS_W'(28)) begin
          san_nxt = san_sh;
          if (pos_r == lxm_pkg::POS_W'(27) && san_sh != lxm_pkg::SANITY) begin
            flags_nxt[0] = 1'b1;
          end
        end else if (pos_r < lxm_pkg::POS_W'(32)) begin
          time_nxt = {time_r[23:0], dec};
        end else begin
          if (32'(idx) >= 32'(cap_r) || 32'(idx) >= 32'(lxm_pkg::MAX_PLAIN_BYTES)) begin
            flags_nxt[1] = 1'b1;
          end
          emit = (flags_nxt == 2'b00);
        end
      end
      if (pos_r != '1) begin
        pos_nxt = pos_r + lxm_pkg::POS_W'(1);
      end
      hold_emit_nxt = emit;
      hold_d_nxt    = dec;
    end
    // message state back to reset once the final result is loaded
    if (cmd.final_load) begin
      pos_nxt       = '0;
      key_nxt       = '0;
      san_nxt       = '0;
      time_nxt      = '0;
      exp_nxt       = '0;
      flags_nxt     = '0;
      hold_emit_nxt = 1'b0;
    end
  end

  // finalization byte source
  always_comb begin
    case (fph_r)
      lxm_pkg::FP_SALT: fin_b = lxm_pkg::SALT_TAB[{sel_r, fcnt_r}];
      lxm_pkg::FP_PAD:  fin_b = 8'h80;
      lxm_pkg::FP_ZERO: fin_b = 8'h00;
      lxm_pkg::FP_LEN:  fin_b = lenb_r[{fcnt_r[2:0], 3'b000} +: 8];
      default:          fin_b = 8'h00;
    endcase
  end

  assign wr_en   = (cmd.accept && pos_r >= lxm_pkg::POS_W'(24)) || cmd.fin_byte;
  assign wr_byte = cmd.accept ? in_byte : fin_b;

  // final status, by precedence
  always_comb begin
    if (pos_r < lxm_pkg::POS_W'(32))  st = lxm_pkg::STAT_SHORT;
    else if (flags_r[1])              st = lxm_pkg::STAT_CAP;
    else if (flags_r[0])              st = lxm_pkg::STAT_SANITY;
    else if (!match)                  st = lxm_pkg::STAT_DIGEST;
    else                              st = lxm_pkg::STAT_OK;
  end

  // message block buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_r[n[5:2]][{n[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  // MD5 round unit
  logic [1:0]  rq;
  logic [31:0] f, t, rot_in, b_new;
  logic [3:0]  g;
  logic [63:0] rot2;
  always_comb begin
    rq = rnd_r[5:4];
    case (rq)
      2'd0: begin
        f = (b_r & c_r) | (~b_r & d_r);
        g = rnd_r[3:0];
      end
      2'd1: begin
        f = (d_r & b_r) | (~d_r & c_r);
        g = 4'(rnd_r * 3'd5 + 6'd1);
      end
      2'd2: begin
        f = b_r ^ c_r ^ d_r;
        g = 4'(rnd_r * 2'd3 + 6'd5);
      end
      default: begin
        f = c_r ^ (b_r | ~d_r);
        g = 4'(rnd_r * 3'd7);
      end
    endcase
    t      = a_r + f + lxm_pkg::MD5_K[rnd_r] + buf_r[g];
    rot_in = t;
    rot2   = {rot_in, rot_in} << lxm_pkg::MD5_S[{rq, rnd_r[1:0]}];
    b_new  = b_r + rot2[63:32];
  end

  // sequential state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      key_r       <= '0;
      san_r       <= '0;
      time_r      <= '0;
      exp_r       <= '0;
      flags_r     <= '0;
      hold_emit_r <= 1'b0;
      hold_d_r    <= '0;
      cnt_r       <= '0;
      h_r[0]      <= lxm_pkg::IV0;
      h_r[1]      <= lxm_pkg::IV1;
      h_r[2]      <= lxm_pkg::IV2;
      h_r[3]      <= lxm_pkg::IV3;
      rnd_r       <= '0;
      fph_r       <= lxm_pkg::FP_SALT;
      fcnt_r      <= '0;
      ov_r        <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      key_r       <= key_nxt;
      san_r       <= san_nxt;
      time_r      <= time_nxt;
      exp_r       <= exp_nxt;
      flags_r     <= flags_nxt;
      hold_emit_r <= hold_emit_nxt;
      hold_d_r    <= hold_d_nxt;

      if (wr_en) begin
        cnt_r <= cnt_r + lxm_pkg::CNT_W'(1);
      end

      // compression
      if (cmd.comp_load) begin
        a_r   <= h_r[0];
        b_r   <= h_r[1];
        c_r   <= h_r[2];
        d_r   <= h_r[3];
        rnd_r <= '0;
      end else if (cmd.round) begin
        a_r   <= d_r;
        b_r   <= b_new;
        c_r   <= b_r;
        d_r   <= c_r;
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          h_r[0] <= h_r[0] + d_r;
          h_r[1] <= h_r[1] + b_new;
          h_r[2] <= h_r[2] + b_r;
          h_r[3] <= h_r[3] + c_r;
        end
      end

      // padding sequencer
      if (cmd.accept) begin
        fph_r  <= lxm_pkg::FP_SALT;
        fcnt_r <= '0;
      end else if (cmd.fin_byte) begin
        case (fph_r)
          lxm_pkg::FP_SALT: begin
            fcnt_r <= fcnt_r + 6'd1;
            if (fcnt_r == 6'd63) fph_r <= lxm_pkg::FP_PAD;
          end
          lxm_pkg::FP_PAD: begin
            lenb_r <= {cnt_r, 3'b000};
            fcnt_r <= '0;
            fph_r  <= (n == 6'd55) ? lxm_pkg::FP_LEN : lxm_pkg::FP_ZERO;
          end
          lxm_pkg::FP_ZERO: begin
            if (n == 6'd55) fph_r <= lxm_pkg::FP_LEN;
          end
          lxm_pkg::FP_LEN: fcnt_r <= fcnt_r + 6'd1;
          default: fph_r <= lxm_pkg::FP_SALT;
        endcase
      end

      // output register
      if (cmd.final_load) begin
        ov_r        <= 1'b1;
        oplain_r    <= hold_emit_r ? hold_d_r : 8'h00;
        oplain_bv_r <= hold_emit_r;
        odone_r     <= 1'b1;
        ostat_r     <= st;
        otime_r     <= (st == lxm_pkg::STAT_OK) ? time_r : 32'h0;
        if (pos_r < lxm_pkg::POS_W'(32))      olen_r <= '0;
        else if (len_m32 > lxm_pkg::POS_W'({lxm_pkg::CAP_W{1'b1}}))
          olen_r <= '1;
        else                                  olen_r <= len_m32[lxm_pkg::CAP_W-1:0];
        // MD5 state back to reset
        cnt_r       <= '0;
        h_r[0]      <= lxm_pkg::IV0;
        h_r[1]      <= lxm_pkg::IV1;
        h_r[2]      <= lxm_pkg::IV2;
        h_r[3]      <= lxm_pkg::IV3;
      end else if (cmd.accept && emit && !in_last) begin
        ov_r        <= 1'b1;
        oplain_r    <= dec;
        oplain_bv_r <= 1'b1;
        odone_r     <= 1'b0;
        ostat_r     <= lxm_pkg::STAT_OK;
        otime_r     <= '0;
        olen_r      <= '0;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_plain = oplain_r;
  assign out_bv    = oplain_bv_r;
  assign out_done  = odone_r;
  assign out_stat  = ostat_r;
  assign out_time  = otime_r;
  assign out_len   = olen_r;

endmodule
`default_nettype wire

>>> hw/rtl/lcg_xor_message_decrypt_md5_check.sv
// Top level of the LCG XOR stream decryptor with salted MD5 check.
`timescale 1ns / 1ps
`default_nettype none
// Takes one ciphertext byte per input transaction and returns one output
// transaction per emitted plaintext byte but the last, which is carried by the
// final status transaction. A byte that completes a 64-byte MD5 block makes
// the intake wait while the single-round MD5 unit compresses the block. After
// the final byte the salt, padding and length (73 to 136 bytes, one per cycle
// outside compression) are run, and the status transaction is loaded once the
// output register is free. Configuration must be written only while idle; the
// block itself does not enforce this.
module lcg_xor_message_decrypt_md5_check (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [16:0] cfg_wdata,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] cipher_byte
  input  wire logic        in_tlast,   // last_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [7:0] plain_byte, [10:8] status,
                                       // [42:11] time_value, [59:43] plain_length
  output logic             out_tuser,  // byte_valid
  output logic             out_tlast   // done_res
);

  lxm_pkg::cmd_t cmd;
  lxm_pkg::sts_t sts;
  logic [7:0]  o_plain;
  logic [2:0]  o_stat;
  logic [31:0] o_time;
  logic [16:0] o_len;

  lxm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lxm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_plain  (o_plain),
    .out_bv     (out_tuser),
    .out_done   (out_tlast),
    .out_stat   (o_stat),
    .out_time   (o_time),
    .out_len    (o_len)
  );

  assign out_tdata = {4'b0000, o_len, o_time, o_stat, o_plain};

endmodule
`default_nettype wire
